// ----- hw/rtl/qots_pkg.sv -----
// Shared types, constants and helper functions for the outline segmenter.
`default_nettype none

package qots_pkg;

   // Width of coordinates once moved into output space
   localparam int CoordWidth    = 16;
   // Width of the fixed input and output coordinate fields
   localparam int FieldWidth    = 16;
   // Result queue
   localparam int FifoDepth     = 4;
   localparam int PtrWidth      = $clog2(FifoDepth);
   localparam int CountWidth    = $clog2(FifoDepth + 1);
   // Configuration registers
   localparam int NumCsr        = 2;
   localparam int CsrIndexWidth = $clog2(NumCsr);

   localparam logic [CsrIndexWidth-1:0] CSR_X_SHIFT = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_Y_TOP   = CsrIndexWidth'(1);

   // Segment kinds
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_QUAD  = 2'd2;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [FieldWidth-1:0] field_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      field_type point_x;
      field_type point_y;
      logic      on_outline;
      logic      contour_first;
      logic      glyph_last;
   } item_type;

   typedef struct packed {
      logic [1:0] seg_kind;
      field_type  end_x;
      field_type  end_y;
      field_type  ctrl_x;
      field_type  ctrl_y;
      logic       closes_contour;
      logic       glyph_done;
   } seg_type;

   // Up to two results pushed into the queue per processed point
   typedef struct packed {
      logic [1:0] count;
      seg_type    first;
      seg_type    second;
   } push_type;

   // Implied on-curve point: sum halved, truncated toward zero, wrapped
   function automatic coord_type midpoint(input coord_type a, input coord_type b);
      logic signed [CoordWidth:0] sum;
      logic signed [CoordWidth:0] halved;
      sum    = {a[CoordWidth-1], a} + {b[CoordWidth-1], b};
      // bias negative sums so the shift rounds toward zero
      sum    = sum + {{CoordWidth{1'b0}}, sum[CoordWidth]};
      halved = sum >>> 1;
      return halved[CoordWidth-1:0];
   endfunction

   function automatic field_type to_field(input coord_type c);
      return c[FieldWidth-1:0];
   endfunction

   function automatic seg_type make_close(input point_type start, input point_type last_on,
                                          input point_type ctrl, input logic prev_on,
                                          input logic done);
      seg_type s;
      s.closes_contour = 1'b1;
      s.glyph_done     = done;
      s.end_x          = to_field(start.x);
      s.end_y          = to_field(start.y);
      s.ctrl_x         = '0;
      s.ctrl_y         = '0;
      if (start == last_on) begin
         s.seg_kind = KIND_EMPTY;
         s.end_x    = '0;
         s.end_y    = '0;
      end else if (prev_on) begin
         s.seg_kind = KIND_LINE;
      end else begin
         s.seg_kind = KIND_QUAD;
         s.ctrl_x   = to_field(ctrl.x);
         s.ctrl_y   = to_field(ctrl.y);
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qots_fifo.sv -----
// Result queue: takes up to two segments per cycle, delivers one per cycle when popped.
`default_nettype none

module qots_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire qots_pkg::push_type  push,
   output logic                     room,
   input  wire                      pop,
   output logic                     head_valid,
   output qots_pkg::seg_type        head
);

   qots_pkg::seg_type                      entries_ff [qots_pkg::FifoDepth];
   logic [qots_pkg::PtrWidth-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [qots_pkg::PtrWidth-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [qots_pkg::CountWidth-1:0]        count_ff, count_in;
   logic [qots_pkg::PtrWidth-1:0]          wr_ptr_next;

   // room for a full pair of results regardless of pops
   assign room       = count_ff <= qots_pkg::CountWidth'(qots_pkg::FifoDepth - 2);
   assign head_valid = count_ff != '0;
   assign head       = entries_ff[rd_ptr_ff];

   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + qots_pkg::PtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + qots_pkg::PtrWidth'(pop);
      count_in  = count_ff + qots_pkg::CountWidth'(push.count)
                  - qots_pkg::CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.second;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= qots_pkg::CountWidth'(qots_pkg::FifoDepth))
      else $error("result queue occupancy out of range");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty result queue");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("push into result queue without room");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/qots_core.sv -----
// Contour state and per-point segment generation.
`default_nettype none

module qots_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      consume,
   input  wire qots_pkg::item_type  item,
   input  wire  [15:0]              x_shift,
   input  wire  signed [15:0]       y_top,
   output qots_pkg::push_type       push
);

   qots_pkg::point_type start_pt_ff,     start_pt_in;
   qots_pkg::point_type last_on_pt_ff,   last_on_pt_in;
   qots_pkg::point_type last_ctrl_pt_ff, last_ctrl_pt_in;
   logic                prev_was_on_ff,  prev_was_on_in;
   logic                in_glyph_ff,     in_glyph_in;

   qots_pkg::point_type p;
   qots_pkg::seg_type   seg;
   qots_pkg::seg_type   close_old;
   qots_pkg::seg_type   close_new;
   logic                contour_start;
   logic                seg_valid;
   logic                old_valid;

   // move the point into output space
   always_comb begin
      p.x = qots_pkg::coord_type'(item.point_x) + qots_pkg::coord_type'(x_shift);
      p.y = qots_pkg::coord_type'(y_top) - qots_pkg::coord_type'(item.point_y);
   end

   assign contour_start = item.contour_first || !in_glyph_ff;

   // next state and the ordinary segment
   always_comb begin
      start_pt_in     = start_pt_ff;
      last_on_pt_in   = last_on_pt_ff;
      last_ctrl_pt_in = last_ctrl_pt_ff;
      in_glyph_in     = in_glyph_ff;
      seg_valid       = 1'b0;
      seg             = '0;
      seg.seg_kind    = qots_pkg::KIND_LINE;
      seg.end_x       = qots_pkg::to_field(p.x);
      seg.end_y       = qots_pkg::to_field(p.y);

      if (contour_start) begin
         start_pt_in = p;
         in_glyph_in = 1'b1;
      end else begin
         if (prev_was_on_ff) begin
            seg_valid = item.on_outline;
         end else begin
            seg_valid    = 1'b1;
            seg.seg_kind = qots_pkg::KIND_QUAD;
            seg.ctrl_x   = qots_pkg::to_field(last_ctrl_pt_ff.x);
            seg.ctrl_y   = qots_pkg::to_field(last_ctrl_pt_ff.y);
            if (!item.on_outline) begin
               seg.end_x = qots_pkg::to_field(qots_pkg::midpoint(last_ctrl_pt_ff.x, p.x));
               seg.end_y = qots_pkg::to_field(qots_pkg::midpoint(last_ctrl_pt_ff.y, p.y));
            end
         end
         if (!item.on_outline) begin
            last_ctrl_pt_in = p;
         end
      end

      if (item.on_outline) begin
         last_on_pt_in = p;
      end
      prev_was_on_in = item.on_outline;

      if (item.glyph_last) begin
         in_glyph_in = 1'b0;
      end
   end

   // closes: the open contour before a new start, and the final one of the glyph
   assign old_valid = contour_start && in_glyph_ff;
   assign close_old = qots_pkg::make_close(start_pt_ff, last_on_pt_ff, last_ctrl_pt_ff,
                                           prev_was_on_ff, 1'b0);
   assign close_new = qots_pkg::make_close(start_pt_in, last_on_pt_in, last_ctrl_pt_in,
                                           prev_was_on_in, 1'b1);

   // order the results into the queue push
   always_comb begin
      push.count  = 2'd0;
      push.first  = close_new;
      push.second = close_new;
      if (consume) begin
         if (old_valid || seg_valid) begin
            push.first = old_valid ? close_old : seg;
            push.count = item.glyph_last ? 2'd2 : 2'd1;
         end else if (item.glyph_last) begin
            push.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pt_ff     <= '0;
         last_on_pt_ff   <= '0;
         last_ctrl_pt_ff <= '0;
         prev_was_on_ff  <= 1'b1;
         in_glyph_ff     <= 1'b0;
      end else if (consume) begin
         start_pt_ff     <= start_pt_in;
         last_on_pt_ff   <= last_on_pt_in;
         last_ctrl_pt_ff <= last_ctrl_pt_in;
         prev_was_on_ff  <= prev_was_on_in;
         in_glyph_ff     <= in_glyph_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/quadratic_outline_to_segments.sv -----
// Top level: glyph points in, line and quadratic outline segments out.
// Path: a point goes from the input register through the core into the result
// queue, whose head drives the outputs; a second result from the same point
// queues behind the first. Throughput: one point per cycle while the queue has room
// for a full pair of results; points giving two results are absorbed by the queue.
// Reset: synchronous, active high; clears the pipeline, the queue, the contour state
// and both configuration registers.
`default_nettype none

module quadratic_outline_to_segments (
   input  wire                                   clock,
   input  wire                                   reset,
   // input points
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [15:0]                    req_point_x,
   input  wire  signed [15:0]                    req_point_y,
   input  wire                                   req_on_outline,
   input  wire                                   req_contour_first,
   input  wire                                   req_glyph_last,
   // result segments
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [1:0]                            rsp_seg_kind,
   output logic signed [15:0]                    rsp_end_x,
   output logic signed [15:0]                    rsp_end_y,
   output logic signed [15:0]                    rsp_ctrl_x,
   output logic signed [15:0]                    rsp_ctrl_y,
   output logic                                  rsp_closes_contour,
   output logic                                  rsp_glyph_done,
   // configuration
   input  wire                                   csr_write,
   input  wire  [qots_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [15:0]                           csr_wdata
);

   logic [15:0]         x_shift_ff;
   logic signed [15:0]  y_top_ff;
   qots_pkg::item_type  item_ff, item_in;
   logic                item_vld_ff, item_vld_in;
   logic                room;
   logic                consume;
   logic                pop;
   qots_pkg::push_type  push;
   qots_pkg::seg_type   head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_shift_ff <= '0;
         y_top_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            qots_pkg::CSR_X_SHIFT: x_shift_ff <= csr_wdata;
            qots_pkg::CSR_Y_TOP:   y_top_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register; held while the queue cannot take a full pair
   assign consume   = item_vld_ff && room;
   assign req_stall = item_vld_ff && !room;

   always_comb begin
      item_in.point_x       = req_point_x;
      item_in.point_y       = req_point_y;
      item_in.on_outline    = req_on_outline;
      item_in.contour_first = req_contour_first;
      item_in.glyph_last    = req_glyph_last;
      item_vld_in           = req_stall ? item_vld_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= item_in;
      end
   end

   qots_core u_core (
      .clock   (clock),
      .reset   (reset),
      .consume (consume),
      .item    (item_ff),
      .x_shift (x_shift_ff),
      .y_top   (y_top_ff),
      .push    (push)
   );

   qots_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head       (head)
   );

   // result transaction
   assign pop                = rsp_valid && !rsp_stall;
   assign rsp_seg_kind       = head.seg_kind;
   assign rsp_end_x          = head.end_x;
   assign rsp_end_y          = head.end_y;
   assign rsp_ctrl_x         = head.ctrl_x;
   assign rsp_ctrl_y         = head.ctrl_y;
   assign rsp_closes_contour = head.closes_contour;
   assign rsp_glyph_done     = head.glyph_done;

`ifndef NO_ASSERTIONS
   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_glyph_done) |-> rsp_closes_contour)
      else $error("glyph end segment does not close a contour");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_seg_kind == qots_pkg::KIND_EMPTY)
         |-> (rsp_end_x == '0 && rsp_end_y == '0 && rsp_closes_contour))
      else $error("empty close carries coordinates");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("result or stall asserted straight after reset");
`endif

endmodule

`default_nettype wire
